// ===== rtl/core/plli_pkg.sv =====
// Shared constants and interface types for the packet loss/latency impairment block.
`timescale 1ns / 1ps

package plli_pkg;

  localparam logic [31:0] GenReset = 32'hDEAD_BEEF;
  localparam logic [31:0] LcgMul   = 32'd1664525;
  localparam logic [31:0] LcgAdd   = 32'd1013904223;
  localparam logic [31:0] PpmScale = 32'd1000000;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_LOSS_RATE = 3'd0,
    REG_MIN_LAT   = 3'd1,
    REG_MAX_LAT   = 3'd2,
    REG_JITTER    = 3'd3,
    REG_SEED      = 3'd4
  } reg_idx_e;

  // request into the shared modulo unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // status back from the modulo unit
  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/plli_mod.sv =====
// Iterative 32-bit modulo unit: restoring division, one quotient bit per cycle.
`timescale 1ns / 1ps

module plli_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plli_pkg::div_req_t req_i,
  output plli_pkg::div_rsp_t rsp_o
);
  import plli_pkg::*;

  logic        active_q, active_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] trial;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    trial    = {rem_q, dvd_q[31]};
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = '0;
      dvd_d    = req_i.dividend;
      dsr_d    = req_i.divisor;
    end else if (active_q) begin
      // remainder always stays below the divisor, so 33 bits cover the trial
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 32'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[31:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/core/packet_loss_latency_impairment.sv =====
// Top level: packet drop and delay decision driven by a 32-bit LCG and a shared modulo unit.
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_ready    direction
//   out       out   out_valid/out_ready  dropped, delay_ms, direction_out
//   cfg       in    APB psel/penable     loss rate, latency limits, jitter, seed
//
// Each draw is a generator step (S_DRAW), a load (S_LOAD) and the bit-serial
// modulo unit (S_DIV); a packet takes up to three draws.
// The modulo unit is the one shared resource.
// Reset (async, active low) leaves the generator at 0xDEADBEEF and the configuration registers at zero.
// A finished result waits in the output register; the next packet is taken
// meanwhile, and the sequencer only holds when a second result is ready.
`timescale 1ns / 1ps

module packet_loss_latency_impairment #(
  parameter int unsigned LATENCY_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       direction_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       dropped_o,
  output logic [16:0]                delay_ms_o,
  output logic                       direction_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plli_pkg::AddrW-1:0] paddr,
  input  logic [plli_pkg::DataW-1:0] pwdata,
  output logic [plli_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import plli_pkg::*;

  localparam int unsigned LatW = (LATENCY_BITS < 16) ? LATENCY_BITS : 16;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DRAW = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    PH_LOSS = 2'd0,
    PH_BASE = 2'd1,
    PH_JIT  = 2'd2
  } phase_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;

  logic [19:0] loss_q;
  logic [15:0] min_q, max_q;
  logic [14:0] jit_q;
  logic [31:0] seed_q;
  logic [31:0] gen_q;

  logic        dir_q, dir_d;
  logic        drop_q, drop_d;
  logic [16:0] lat_q, lat_d;

  logic        out_valid_q, out_valid_d;
  logic        out_drop_q;
  logic [16:0] out_delay_q;
  logic        out_dir_q;
  logic        out_load;

  logic        wr_en;
  reg_idx_e    wr_idx;
  logic [15:0] lo, hi;
  logic [15:0] span;
  logic        lohi_zero;
  logic [18:0] jit_sum;
  logic [31:0] gen_next;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    unique case (wr_idx)
      REG_LOSS_RATE: prdata = {12'd0, loss_q};
      REG_MIN_LAT:   prdata = {16'd0, min_q};
      REG_MAX_LAT:   prdata = {16'd0, max_q};
      REG_JITTER:    prdata = {17'd0, jit_q};
      REG_SEED:      prdata = seed_q;
      default:       prdata = '0;
    endcase
  end

  // ---------------- derived operands ----------------
  always_comb begin
    lo = '0;
    hi = '0;
    lo[LatW-1:0] = min_q[LatW-1:0];
    hi[LatW-1:0] = max_q[LatW-1:0];
  end

  assign lohi_zero = (lo == '0) && (hi == '0);
  assign span      = (hi >= lo) ? (hi - lo) : '0;
  assign gen_next  = gen_q * LcgMul + LcgAdd;
  // base + jitter draw - jitter; kept only when strictly positive
  assign jit_sum   = {2'b00, lat_q} + {3'b000, div_rsp.rem[15:0]} - {4'b0000, jit_q};

  always_comb begin
    div_req.start    = (state_q == S_LOAD);
    div_req.dividend = gen_q;
    case (phase_q)
      PH_LOSS: div_req.divisor = PpmScale;
      PH_BASE: div_req.divisor = {15'd0, 17'({1'b0, span} + 17'd1)};
      PH_JIT:  div_req.divisor = {16'd0, {jit_q, 1'b1}};
      default: div_req.divisor = PpmScale;
    endcase
  end

  plli_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- sequencer ----------------
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    dir_d   = dir_q;
    drop_d  = drop_q;
    lat_d   = lat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dir_d  = direction_i;
          drop_d = 1'b0;
          lat_d  = '0;
          if (loss_q != '0) begin
            phase_d = PH_LOSS;
            state_d = S_DRAW;
          end else if (lohi_zero) begin
            state_d = S_FIN;
          end else begin
            phase_d = PH_BASE;
            state_d = S_DRAW;
          end
        end
      end
      S_DRAW: state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          case (phase_q)
            PH_LOSS: begin
              if (div_rsp.rem < {12'd0, loss_q}) begin
                drop_d  = 1'b1;
                state_d = S_FIN;
              end else if (lohi_zero) begin
                state_d = S_FIN;
              end else begin
                phase_d = PH_BASE;
                state_d = S_DRAW;
              end
            end
            PH_BASE: begin
              lat_d = 17'({1'b0, lo} + div_rsp.rem[16:0]);
              if (jit_q != '0) begin
                phase_d = PH_JIT;
                state_d = S_DRAW;
              end else begin
                state_d = S_FIN;
              end
            end
            default: begin
              if (!jit_sum[18] && (jit_sum != '0)) begin
                lat_d = jit_sum[16:0];
              end
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_LOSS;
      out_valid_q <= 1'b0;
      loss_q      <= '0;
      min_q       <= '0;
      max_q       <= '0;
      jit_q       <= '0;
      seed_q      <= '0;
      gen_q       <= GenReset;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      // a nonzero seed write reloads the generator
      if (wr_en && (wr_idx == REG_SEED) && (pwdata != '0)) begin
        gen_q <= pwdata;
      end else if (state_q == S_DRAW) begin
        gen_q <= gen_next;
      end
      if (wr_en) begin
        unique case (wr_idx)
          REG_LOSS_RATE: loss_q <= pwdata[19:0];
          REG_MIN_LAT:   min_q  <= pwdata[15:0];
          REG_MAX_LAT:   max_q  <= pwdata[15:0];
          REG_JITTER:    jit_q  <= pwdata[14:0];
          REG_SEED:      seed_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    drop_q <= drop_d;
    lat_q  <= lat_d;
    if (out_load) begin
      out_drop_q  <= drop_q;
      out_delay_q <= lat_q;
      out_dir_q   <= dir_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign dropped_o       = out_drop_q;
  assign delay_ms_o      = out_delay_q;
  assign direction_out_o = out_dir_q;

endmodule

// ===== rtl/core/plli_checker.sv =====
// Port-level checks for the packet loss/latency impairment block, bound to the top level.
`timescale 1ns / 1ps

module plli_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       dropped_o,
  input logic [16:0]                delay_ms_o,
  input logic                       direction_out_o,
  input logic                       pready
);
  import plli_pkg::*;

  // a held result keeps its payload until the transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dropped_o)
      && $stable(delay_ms_o) && $stable(direction_out_o))
    else $error("result changed while stalled");

  // a dropped packet carries no delay
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> delay_ms_o == 17'd0)
    else $error("dropped packet with nonzero delay");

  // the largest delay is max latency plus max jitter
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> delay_ms_o <= 17'd98302)
    else $error("delay out of range");

  // one packet at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a packet is in work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port stalled");

endmodule

bind packet_loss_latency_impairment plli_checker u_plli_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .dropped_o       (dropped_o),
  .delay_ms_o      (delay_ms_o),
  .direction_out_o (direction_out_o),
  .pready          (pready)
);

// ===== dv/packet_loss_latency_impairment_test.sv =====
// Self-checking testbench for the packet loss/latency impairment block: LCG predictor and scoreboard.
`timescale 1ns / 1ps

module packet_loss_latency_impairment_test;

  localparam int unsigned LatBits     = 16;
  localparam logic [31:0] LatMask     = (32'd1 << LatBits) - 32'd1;
  localparam logic [31:0] LcgMul      = 32'd1664525;
  localparam logic [31:0] LcgAdd      = 32'd1013904223;
  localparam logic [31:0] LcgInit     = 32'hDEAD_BEEF;
  localparam logic [31:0] PpmFull     = 32'd1000000;
  localparam int unsigned NumRegs     = 5;
  localparam int unsigned AddrSlots   = (1 << plli_pkg::AddrW) / 4;
  localparam int unsigned RandomItems = 550;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxReports  = 30;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_STALLS
  } rx_mode_e;

  typedef struct packed {
    logic        dropped;
    logic [16:0] delay_ms;
    logic        direction;
  } impair_result_t;

  // Holds a copy of the register file and generator; predicts one verdict per packet.
  class impair_scoreboard;
    logic [19:0]    loss_ppm;
    logic [15:0]    lat_min;
    logic [15:0]    lat_max;
    logic [14:0]    jitter;
    logic [31:0]    seed;
    logic [31:0]    lcg_state;
    impair_result_t verdict_q[$];
    int unsigned    n_in;
    int unsigned    n_out;
    int unsigned    n_drop;
    int unsigned    n_clip;
    int unsigned    n_err;

    function new();
      loss_ppm  = '0;
      lat_min   = '0;
      lat_max   = '0;
      jitter    = '0;
      seed      = '0;
      lcg_state = LcgInit;
      n_in      = 0;
      n_out     = 0;
      n_drop    = 0;
      n_clip    = 0;
      n_err     = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] value);
      case (idx)
        plli_pkg::REG_LOSS_RATE: loss_ppm = value[19:0];
        plli_pkg::REG_MIN_LAT:   lat_min  = value[15:0];
        plli_pkg::REG_MAX_LAT:   lat_max  = value[15:0];
        plli_pkg::REG_JITTER:    jitter   = value[14:0];
        plli_pkg::REG_SEED: begin
          seed = value;
          if (value != '0) lcg_state = value;
        end
        default: ;
      endcase
    endfunction

    function logic [31:0] step_lcg();
      lcg_state = lcg_state * LcgMul + LcgAdd;
      return lcg_state;
    endfunction

    function logic [16:0] pick_delay();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] span;
      logic [31:0] r;
      longint      lat;
      longint      jv;
      lo = {16'b0, lat_min} & LatMask;
      hi = {16'b0, lat_max} & LatMask;
      if (lo == '0 && hi == '0) return '0;
      // inverted limits collapse to the minimum, but the draw still happens
      span = (hi >= lo) ? hi - lo : 32'd0;
      r    = step_lcg();
      lat  = longint'(lo + r % (span + 32'd1));
      if (jitter != '0) begin
        r  = step_lcg() % (32'd2 * {17'b0, jitter} + 32'd1);
        jv = longint'(r) - longint'({17'b0, jitter});
        if (lat + jv > 0) lat = lat + jv;
        else n_clip++;
      end
      return lat[16:0];
    endfunction

    function void note_input(logic dir);
      impair_result_t res;
      res.dropped   = 1'b0;
      res.delay_ms  = '0;
      res.direction = dir;
      if (loss_ppm != '0) res.dropped = (step_lcg() % PpmFull) < {12'b0, loss_ppm};
      if (res.dropped) n_drop++;
      else res.delay_ms = pick_delay();
      verdict_q.push_back(res);
      n_in++;
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      n_err++;
      if (n_err <= MaxReports) $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_result(logic dropped, logic [16:0] delay_ms, logic dir);
      impair_result_t want;
      n_out++;
      if (verdict_q.size() == 0) begin
        n_err++;
        if (n_err <= MaxReports) $error("result transfer with no packet outstanding");
        return;
      end
      want = verdict_q.pop_front();
      if (dropped !== want.dropped) flag("dropped", want.dropped, dropped);
      if (delay_ms !== want.delay_ms) flag("delay_ms", want.delay_ms, delay_ms);
      if (dir !== want.direction) flag("direction_out", want.direction, dir);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic                       direction_i     = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic                       dropped_o;
  logic [16:0]                delay_ms_o;
  logic                       direction_out_o;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [plli_pkg::AddrW-1:0] paddr           = '0;
  logic [plli_pkg::DataW-1:0] pwdata          = '0;
  logic [plli_pkg::DataW-1:0] prdata;
  logic                       pready;

  impair_scoreboard sb;
  int unsigned      cycles = 0;
  int unsigned      phases = 0;

  packet_loss_latency_impairment #(
    .LATENCY_BITS(LatBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .direction_i    (direction_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dropped_o      (dropped_o),
    .delay_ms_o     (delay_ms_o),
    .direction_out_o(direction_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(dropped_o, delay_ms_o, direction_out_o);
    end
  end

  // receiver backpressure: stretches of different stall behavior
  initial begin
    rx_mode_e    mode;
    int unsigned stretch;
    int unsigned stall;
    stall = 0;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(20, 300);
      repeat (stretch) begin
        @(posedge clk_i);
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: begin
            if (stall != 0) begin
              stall--;
              out_ready_i <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
              stall = $urandom_range(5, 40);
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // idle bus phase, setup, access; the register updates at the access edge
  task automatic apb_write(input int unsigned idx, input logic [31:0] value);
    wait_idle();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= plli_pkg::AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned width, bit dirty);
    return dirty ? (value | ($urandom << width)) : value;
  endfunction

  task automatic set_config(input logic [31:0] loss, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [31:0] jit, input bit dirty);
    apb_write(plli_pkg::REG_LOSS_RATE, with_junk(loss, 20, dirty));
    apb_write(plli_pkg::REG_MIN_LAT, with_junk(lo, 16, dirty));
    apb_write(plli_pkg::REG_MAX_LAT, with_junk(hi, 16, dirty));
    apb_write(plli_pkg::REG_JITTER, with_junk(jit, 15, dirty));
    phases++;
  endtask

  // valid stays up across back-to-back transfers; the predictor is fed at the accepting edge
  task automatic send_packet(input logic dir);
    in_valid_i  <= 1'b1;
    direction_i <= dir;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(dir);
  endtask

  task automatic run_packets(input int unsigned count, input bit no_gaps);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_packet(logic'($urandom_range(0, 1)));
      left -= burst;
      gap = $urandom_range(0, 30);
      if (!no_gaps && left > 0 && gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [31:0] loss;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] jit;
    case ($urandom_range(0, 9))
      0, 1, 2: loss = 0;
      3:       loss = PpmFull;
      4:       loss = $urandom_range(1000001, 1048575);
      5:       loss = $urandom_range(1, 1000);
      default: loss = $urandom_range(1, 999999);
    endcase
    case ($urandom_range(0, 7))
      0: begin lo = 0; hi = 0; end
      1: begin lo = 65535; hi = 65535; end
      2: begin lo = $urandom_range(1, 65535); hi = $urandom_range(0, lo - 1); end
      3: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
      default: begin lo = $urandom_range(0, 200); hi = lo + $urandom_range(0, 100); end
    endcase
    case ($urandom_range(0, 7))
      0:       jit = 0;
      1:       jit = 32767;
      2:       jit = $urandom_range(1, 8);
      3, 4, 5: jit = $urandom_range(1, 300);
      default: jit = $urandom_range(0, 32767);
    endcase
    set_config(loss, lo, hi, jit, $urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) begin
      apb_write(plli_pkg::REG_SEED, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: no drop test, zero delay
    run_packets(2, 1'b1);
    // zero limits with jitter set: still zero delay and no draws
    set_config(0, 0, 0, 100, 1'b0);
    run_packets(2, 1'b1);
    // full loss rate and the largest rate the field holds
    set_config(PpmFull, 0, 0, 0, 1'b0);
    run_packets(2, 1'b0);
    set_config(32'hF_FFFF, 10, 20, 5, 1'b0);
    run_packets(2, 1'b1);
    // largest delay reach
    set_config(0, 65535, 65535, 32767, 1'b0);
    run_packets(2, 1'b1);
    // inverted limits
    set_config(0, 100, 50, 0, 1'b0);
    run_packets(2, 1'b1);
    // zero seed leaves the generator alone, then all-ones seed
    apb_write(plli_pkg::REG_SEED, 32'd0);
    run_packets(1, 1'b1);
    apb_write(plli_pkg::REG_SEED, 32'hFFFF_FFFF);
    set_config(0, 0, 65535, 0, 1'b0);
    run_packets(2, 1'b1);
    // jitter that would push the delay to zero or below, a one-ppm loss rate without jitter, and half loss
    set_config(0, 1, 1, 5, 1'b0);
    run_packets(3, 1'b1);
    set_config(1, 0, 10, 0, 1'b0);
    run_packets(2, 1'b1);
    set_config(500000, 0, 1, 32767, 1'b0);
    run_packets(2, 1'b1);
    // unmapped registers ignored, upper bits of a field ignored
    for (int unsigned i = NumRegs; i < AddrSlots; i++) apb_write(i, $urandom);
    apb_write(plli_pkg::REG_JITTER, 32'hFFFF_8003);
    run_packets(1, 1'b1);

    sent = 0;
    while (sent < RandomItems) begin
      random_config();
      n = $urandom_range(10, 45);
      if (n > RandomItems - sent) n = RandomItems - sent;
      run_packets(n, $urandom_range(0, 5) == 0);
      sent += n;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d packet transfers over %0d register settings; %0d predicted drops,",
             sb.n_in, phases, sb.n_drop);
    $display("%0d jitter draws clipped; %0d result transfers checked, %0d mismatches.",
             sb.n_clip, sb.n_out, sb.n_err);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
